[rtl/core/sdi_pkg.sv]
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants of the stroke dab interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package sdi_pkg;

   localparam int CW           = 16;  // coordinate width
   localparam int PW           = 9;   // pressure width, q1.8
   localparam int DW           = 17;  // divider and root width
   localparam int MAX_DABS_DEF = 64;

   localparam logic [1:0] REG_STAB  = 2'd0;
   localparam logic [1:0] REG_RATIO = 2'd1;
   localparam logic [1:0] REG_SIZE  = 2'd2;

   typedef struct packed {
      logic [CW-1:0] start_x;
      logic [CW-1:0] start_y;
      logic [PW-1:0] start_pressure;
      logic [CW-1:0] end_x;
      logic [CW-1:0] end_y;
      logic [PW-1:0] end_pressure;
   } req_type;

   typedef struct packed {
      logic [CW-1:0] dab_x;
      logic [CW-1:0] dab_y;
      logic [PW-1:0] dab_pressure;
      logic          last_dab;
      logic          clipped;
   } rsp_type;

   typedef struct packed {
      logic          start;
      logic [DW-1:0] dividend;
      logic [DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [DW-1:0] quot;
      logic [DW-1:0] rem;
   } div_rsp_type;

endpackage
`default_nettype wire

[rtl/core/sdi_div.sv]
// ----------------------------------------------------------------------------
// sdi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sdi_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sdi_pkg::div_req_type req,
   output sdi_pkg::div_rsp_type      rsp
);
   localparam int DW = sdi_pkg::DW;
   localparam int NB = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NB-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quot_ff, quot_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   sh;
   logic          ge;

   always_comb begin
      sh      = {rem_ff, quot_ff[DW-1]};
      ge      = sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = NB'(DW);
         rem_in  = '0;
         quot_in = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? DW'(sh - {1'b0, dvs_ff}) : sh[DW-1:0];
         quot_in = {quot_ff[DW-2:0], ge};
         cnt_in  = cnt_ff - NB'(1);
         if (cnt_ff == NB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule
`default_nettype wire

[rtl/core/stroke_dab_interpolator.sv]
// ----------------------------------------------------------------------------
// stroke_dab_interpolator
// Splits a stroke segment into evenly spaced brush dabs, one beat per dab.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_      in         req_valid/stall     segment (sdi_pkg::req_type)
//  rsp_      out        rsp_valid/stall     one dab (sdi_pkg::rsp_type)
//  apb       in         psel/penable/pready stabilization, spacing_ratio, size
//
//  a segment passes 6 multiply steps, 17 root steps and 4 divider runs on the
//  single shared multiplier, the bit-serial root and the shared one-bit-a-cycle
//  divider, then one dab per cycle while no rsp beat is held stalled.
//  synchronous reset clears control state and loads register defaults.
//  a stalled rsp beat holds; dab generation waits while a valid rsp beat is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module stroke_dab_interpolator #(
   parameter int MAX_DABS = sdi_pkg::MAX_DABS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sdi_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sdi_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   localparam int CW = sdi_pkg::CW;
   localparam int PW = sdi_pkg::PW;
   localparam int DW = sdi_pkg::DW;
   localparam int NW = $clog2(MAX_DABS + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_ROOT = 6'b000100,
      S_DGO  = 6'b001000,
      S_DWT  = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   // configuration
   logic [8:0]  stab_ff;
   logic [11:0] ratio_ff;
   logic [13:0] size_ff;
   logic        wr;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         stab_ff  <= 9'd0;
         ratio_ff <= 12'd64;
         size_ff  <= 14'd160;
      end else if (wr) begin
         case (paddr[3:2])
            sdi_pkg::REG_STAB:  stab_ff  <= pwdata[8:0];
            sdi_pkg::REG_RATIO: ratio_ff <= pwdata[11:0];
            sdi_pkg::REG_SIZE:  size_ff  <= pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         sdi_pkg::REG_STAB:  prdata = {23'd0, stab_ff};
         sdi_pkg::REG_RATIO: prdata = {20'd0, ratio_ff};
         sdi_pkg::REG_SIZE:  prdata = {18'd0, size_ff};
         default:            prdata = 32'd0;
      endcase
   end

   logic [8:0]  stab_sat;
   logic [8:0]  keep;
   logic        stab_on;
   logic [11:0] ratio_eff;
   assign stab_sat  = (stab_ff > 9'd256) ? 9'd256 : stab_ff;
   assign keep      = 9'd256 - stab_sat;
   assign stab_on   = stab_sat >= 9'd3;
   assign ratio_eff = (ratio_ff < 12'd3) ? 12'd3 : ratio_ff;

   // datapath registers
   state_type     state_ff, state_in;
   logic [2:0]    k_ff, k_in;
   logic [1:0]    dsel_ff, dsel_in;
   logic [CW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [PW-1:0] sp_ff, sp_in;
   logic [CW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [PW-1:0] mp_ff, mp_in;
   logic          nx_ff, nx_in, ny_ff, ny_in, np_ff, np_in;
   logic [33:0]   prod_ff, prod_in;
   logic [32:0]   sum_ff, sum_in;
   logic [DW-1:0] spc_ff, spc_in;
   logic [33:0]   rad_ff, rad_in;
   logic [18:0]   rem_ff, rem_in;
   logic [DW-1:0] root_ff, root_in;
   logic [4:0]    rcnt_ff, rcnt_in;
   logic [NW-1:0] n_ff, n_in, i_ff, i_in;
   logic          clip_ff, clip_in;
   logic [CW-1:0] qx_ff, qx_in, qy_ff, qy_in, bqx_ff, bqx_in, bqy_ff, bqy_in;
   logic [PW-1:0] qp_ff, qp_in, bqp_ff, bqp_in;
   logic [NW-1:0] rx_ff, rx_in, ry_ff, ry_in, rp_ff, rp_in;
   logic [NW-1:0] brx_ff, brx_in, bry_ff, bry_in, brp_ff, brp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sdi_pkg::rsp_type rsp_ff, rsp_in;

   logic [DW-1:0] ma, mb;
   logic [20:0]   rem_sh, trial;
   sdi_pkg::div_req_type dreq;
   sdi_pkg::div_rsp_type drsp;
   logic          fire;
   logic [NW:0]   rxs, rys, rps;
   logic          cx, cy, cp;
   logic [CW-1:0] qxn, qyn;
   logic [PW-1:0] qpn;
   logic [CW:0]   dxs, dys;
   logic [PW-1:0] psat0, psat1;

   sdi_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign psat0 = (req_data.start_pressure > 9'd256) ? 9'd256 : req_data.start_pressure;
   assign psat1 = (req_data.end_pressure > 9'd256) ? 9'd256 : req_data.end_pressure;
   assign dxs   = {1'b0, req_data.end_x} - {1'b0, req_data.start_x};
   assign dys   = {1'b0, req_data.end_y} - {1'b0, req_data.start_y};

   assign req_stall = (state_ff != S_IDLE);
   assign fire      = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // running quotient and remainder of d*i/n
   always_comb begin
      rxs = {1'b0, rx_ff} + {1'b0, brx_ff};
      rys = {1'b0, ry_ff} + {1'b0, bry_ff};
      rps = {1'b0, rp_ff} + {1'b0, brp_ff};
      cx  = rxs >= {1'b0, n_ff};
      cy  = rys >= {1'b0, n_ff};
      cp  = rps >= {1'b0, n_ff};
      qxn = qx_ff + bqx_ff + CW'(cx);
      qyn = qy_ff + bqy_ff + CW'(cy);
      qpn = qp_ff + bqp_ff + PW'(cp);
   end

   always_comb begin
      case (k_ff)
         3'd0:    begin ma = DW'(mx_ff);   mb = DW'(keep);      end
         3'd1:    begin ma = DW'(my_ff);   mb = DW'(keep);      end
         3'd2:    begin ma = DW'(size_ff); mb = DW'(ratio_eff); end
         3'd3:    begin ma = DW'(mx_ff);   mb = DW'(mx_ff);     end
         default: begin ma = DW'(my_ff);   mb = DW'(my_ff);     end
      endcase
      rem_sh = {rem_ff, rad_ff[33:32]};
      trial  = {2'b00, root_ff, 2'b01};
   end

   always_comb begin
      state_in = state_ff;  k_in = k_ff;  dsel_in = dsel_ff;
      sx_in = sx_ff;  sy_in = sy_ff;  sp_in = sp_ff;
      mx_in = mx_ff;  my_in = my_ff;  mp_in = mp_ff;
      nx_in = nx_ff;  ny_in = ny_ff;  np_in = np_ff;
      prod_in = {17'd0, ma} * {17'd0, mb};
      sum_in = sum_ff;  spc_in = spc_ff;
      rad_in = rad_ff;  rem_in = rem_ff;  root_in = root_ff;  rcnt_in = rcnt_ff;
      n_in = n_ff;  i_in = i_ff;  clip_in = clip_ff;
      qx_in = qx_ff;  qy_in = qy_ff;  qp_in = qp_ff;
      rx_in = rx_ff;  ry_in = ry_ff;  rp_in = rp_ff;
      bqx_in = bqx_ff;  bqy_in = bqy_ff;  bqp_in = bqp_ff;
      brx_in = brx_ff;  bry_in = bry_ff;  brp_in = brp_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      dreq.start = 1'b0;
      case (dsel_ff)
         2'd0:    begin dreq.dividend = root_ff;             end
         2'd1:    begin dreq.dividend = DW'(mx_ff);          end
         2'd2:    begin dreq.dividend = DW'(my_ff);          end
         default: begin dreq.dividend = DW'(mp_ff);          end
      endcase
      dreq.divisor = (dsel_ff == 2'd0) ? spc_ff : DW'(n_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sx_in = req_data.start_x;
               sy_in = req_data.start_y;
               sp_in = psat0;
               nx_in = dxs[CW];
               ny_in = dys[CW];
               mx_in = dxs[CW] ? CW'(-dxs) : dxs[CW-1:0];
               my_in = dys[CW] ? CW'(-dys) : dys[CW-1:0];
               np_in = psat1 < psat0;
               mp_in = (psat1 < psat0) ? psat0 - psat1 : psat1 - psat0;
               k_in  = 3'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            k_in = k_ff + 3'd1;
            case (k_ff)
               3'd1: if (stab_on) mx_in = prod_ff[23:8];
               3'd2: if (stab_on) my_in = prod_ff[23:8];
               3'd3: spc_in = (prod_ff[25:9] < DW'(4)) ? DW'(4) : prod_ff[25:9];
               3'd4: sum_in = prod_ff[32:0];
               3'd5: begin
                  rad_in   = {1'b0, sum_ff} + prod_ff;
                  rem_in   = '0;
                  root_in  = '0;
                  rcnt_in  = 5'd17;
                  state_in = S_ROOT;
               end
               default: ;
            endcase
         end
         S_ROOT: begin
            // two radicand bits per step
            rad_in = {rad_ff[31:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = 19'(rem_sh - trial);
               root_in = {root_ff[DW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[18:0];
               root_in = {root_ff[DW-2:0], 1'b0};
            end
            rcnt_in = rcnt_ff - 5'd1;
            if (rcnt_ff == 5'd1) begin
               dsel_in  = 2'd0;
               state_in = S_DGO;
            end
         end
         S_DGO: begin
            dreq.start = 1'b1;
            state_in   = S_DWT;
         end
         S_DWT: begin
            if (drsp.done) begin
               dsel_in  = dsel_ff + 2'd1;
               state_in = S_DGO;
               case (dsel_ff)
                  2'd0: begin
                     clip_in = 1'b0;
                     if (drsp.quot == '0) begin
                        n_in = NW'(1);
                        if (root_ff <= DW'(1)) state_in = S_IDLE;
                     end else if (drsp.quot > DW'(MAX_DABS)) begin
                        n_in    = NW'(MAX_DABS);
                        clip_in = 1'b1;
                     end else begin
                        n_in = drsp.quot[NW-1:0];
                     end
                  end
                  2'd1: begin bqx_in = drsp.quot[CW-1:0]; brx_in = drsp.rem[NW-1:0]; end
                  2'd2: begin bqy_in = drsp.quot[CW-1:0]; bry_in = drsp.rem[NW-1:0]; end
                  default: begin
                     bqp_in = drsp.quot[PW-1:0];
                     brp_in = drsp.rem[NW-1:0];
                     qx_in = '0;  qy_in = '0;  qp_in = '0;
                     rx_in = '0;  ry_in = '0;  rp_in = '0;
                     i_in  = '0;
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (fire) begin
               qx_in = qxn;  qy_in = qyn;  qp_in = qpn;
               rx_in = cx ? NW'(rxs - {1'b0, n_ff}) : rxs[NW-1:0];
               ry_in = cy ? NW'(rys - {1'b0, n_ff}) : rys[NW-1:0];
               rp_in = cp ? NW'(rps - {1'b0, n_ff}) : rps[NW-1:0];
               i_in  = i_ff + NW'(1);
               rsp_in.dab_x        = nx_ff ? sx_ff - qxn : sx_ff + qxn;
               rsp_in.dab_y        = ny_ff ? sy_ff - qyn : sy_ff + qyn;
               rsp_in.dab_pressure = np_ff ? sp_ff - qpn : sp_ff + qpn;
               rsp_in.last_dab     = (i_ff + NW'(1)) == n_ff;
               rsp_in.clipped      = clip_ff;
               rsp_valid_in        = 1'b1;
               if ((i_ff + NW'(1)) == n_ff) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         dsel_ff      <= '0;
         rcnt_ff      <= '0;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         dsel_ff      <= dsel_in;
         rcnt_ff      <= rcnt_in;
         i_ff         <= i_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff <= sx_in;  sy_ff <= sy_in;  sp_ff <= sp_in;
      mx_ff <= mx_in;  my_ff <= my_in;  mp_ff <= mp_in;
      nx_ff <= nx_in;  ny_ff <= ny_in;  np_ff <= np_in;
      prod_ff <= prod_in;  sum_ff <= sum_in;  spc_ff <= spc_in;
      rad_ff <= rad_in;  rem_ff <= rem_in;  root_ff <= root_in;
      n_ff <= n_in;  clip_ff <= clip_in;
      qx_ff <= qx_in;  qy_ff <= qy_in;  qp_ff <= qp_in;
      rx_ff <= rx_in;  ry_ff <= ry_in;  rp_ff <= rp_in;
      bqx_ff <= bqx_in;  bqy_ff <= bqy_in;  bqp_ff <= bqp_in;
      brx_ff <= brx_in;  bry_ff <= bry_in;  brp_ff <= brp_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
